[sv/rqrp_pkg.sv]
// Shared types, constants and codes of the ring queue with prefix reverse.
`default_nettype none
package rqrp_pkg;

  localparam int unsigned MAX_DEPTH  = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(MAX_DEPTH);
  localparam int unsigned CNT_W      = $clog2(MAX_DEPTH + 1);
  localparam int unsigned SUM_W      = ADDR_W + 1;

  typedef enum logic [1:0] {
    FN_ENQ = 2'd0,
    FN_DEQ = 2'd1,
    FN_REV = 2'd2,
    FN_NOP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP,
    S_POP,
    S_SWRD,
    S_SWA,
    S_SWB,
    S_HEAD,
    S_RESP
  } state_e;

  // one write port, two read ports with read enables
  typedef struct packed {
    logic                  re0;
    logic [ADDR_W-1:0]     ra0;
    logic                  re1;
    logic [ADDR_W-1:0]     ra1;
    logic                  we;
    logic [ADDR_W-1:0]     wa;
    logic [DATA_WIDTH-1:0] wd;
  } mem_req_t;

  // finished item, head data comes from read port 0 in the same cycle
  typedef struct packed {
    logic                  valid;
    status_e               status;
    logic [DATA_WIDTH-1:0] popped;
    logic [CNT_W-1:0]      count;
    logic                  empty;
    logic                  full;
  } rsp_t;

endpackage
`default_nettype wire

[sv/ring_queue_reverse_prefix.sv]
// Top level: circular queue with reverse of the oldest k entries.
// An item runs S_OP, its extra states, S_HEAD and S_RESP, then the strobe register;
// a dequeue adds S_POP, a reverse adds S_SWRD, S_SWA and S_SWB for each of its floor(k/2)
// swaps, and a rejected reverse or failed op adds none. The next item is accepted in the
// cycle the result is shown; each swap costs one dual read and two writes on the single
// write port of the entry RAM. Results cannot be stalled.
// Reset: empty queue, capacity 16, head 0, tail 15; the entry RAM is not cleared.
`default_nettype none
module ring_queue_reverse_prefix
  import rqrp_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command side
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   func_i,
  input  wire logic signed [DATA_WIDTH-1:0] push_value_i,
  input  wire logic [CNT_W-1:0]             reverse_count_i,
  // capacity register write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CNT_W-1:0]             cfg_data_i,
  // result side, one cycle per item
  output logic                              res_valid_o,
  output logic signed [DATA_WIDTH-1:0]      pop_value_o,
  output logic [1:0]                        status_o,
  output logic [CNT_W-1:0]                  occupancy_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic signed [DATA_WIDTH-1:0]      head_value_o
);

  mem_req_t              mem_req;
  rsp_t                  rsp;
  logic [DATA_WIDTH-1:0] rd0;
  logic [DATA_WIDTH-1:0] rd1;

  logic                  res_valid_q;
  logic [DATA_WIDTH-1:0] pop_q;
  status_e               status_q;
  logic [CNT_W-1:0]      occ_q;
  logic                  empty_q;
  logic                  full_q;
  logic [DATA_WIDTH-1:0] head_q;

  rqrp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .func_i      (func_i),
    .value_i     (push_value_i),
    .k_i         (reverse_count_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rd0_i       (rd0),
    .rd1_i       (rd1),
    .busy_o      (busy),
    .cfg_ready_o (cfg_ready_o),
    .mem_o       (mem_req),
    .rsp_o       (rsp)
  );

  rqrp_ram u_ram (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd0_o (rd0),
    .rd1_o (rd1)
  );

  // strobe register; cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= rsp.valid;
    end
  end

  // result payload; head word arrives on read port 0 in the finishing cycle
  always_ff @(posedge clk_i) begin
    if (rsp.valid) begin
      pop_q    <= rsp.popped;
      status_q <= rsp.status;
      occ_q    <= rsp.count;
      empty_q  <= rsp.empty;
      full_q   <= rsp.full;
      head_q   <= rsp.empty ? '0 : rd0;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign pop_value_o  = pop_q;
  assign status_o     = status_q;
  assign occupancy_o  = occ_q;
  assign is_empty_o   = empty_q;
  assign is_full_o    = full_q;
  assign head_value_o = head_q;

endmodule
`default_nettype wire

[sv/rqrp_ram.sv]
// Entry store: synchronous RAM, one write port, two registered read ports.
`default_nettype none
module rqrp_ram
  import rqrp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire mem_req_t              req_i,
  output logic [DATA_WIDTH-1:0]      rd0_o,
  output logic [DATA_WIDTH-1:0]      rd1_o
);

  logic [DATA_WIDTH-1:0] mem [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] rd0_q;
  logic [DATA_WIDTH-1:0] rd1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wa] <= req_i.wd;
    end
    if (req_i.re0) begin
      rd0_q <= mem[req_i.ra0];
    end
    if (req_i.re1) begin
      rd1_q <= mem[req_i.ra1];
    end
  end

  assign rd0_o = rd0_q;
  assign rd1_o = rd1_q;

endmodule
`default_nettype wire

[sv/rqrp_seq.sv]
// Sequencer: ring pointers, capacity register and read-modify-write control.
`default_nettype none
module rqrp_seq
  import rqrp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [1:0]            func_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  input  wire logic [CNT_W-1:0]      k_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CNT_W-1:0]      cfg_data_i,
  input  wire logic [DATA_WIDTH-1:0] rd0_i,
  input  wire logic [DATA_WIDTH-1:0] rd1_i,
  output logic                       busy_o,
  output logic                       cfg_ready_o,
  output mem_req_t                   mem_o,
  output rsp_t                       rsp_o
);

  state_e                state_q, state_d;
  logic [ADDR_W-1:0]     head_q, head_d;
  logic [ADDR_W-1:0]     tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cap_q, cap_d;
  func_e                 func_q, func_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [ADDR_W-1:0]     i_q, i_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] pop_q, pop_d;

  logic [CNT_W-1:0]      cap_new;
  logic [CNT_W-1:0]      pos_b;
  logic [ADDR_W-1:0]     slot_a;
  logic [ADDR_W-1:0]     slot_b;
  logic [ADDR_W-1:0]     tail_inc;

  // (base + off) mod cap, valid while base + off stays below twice cap
  function automatic logic [ADDR_W-1:0] wrap_add(
    input logic [ADDR_W-1:0] base,
    input logic [ADDR_W-1:0] off,
    input logic [CNT_W-1:0]  cap
  );
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] capx;
    sum  = {1'b0, base} + {1'b0, off};
    capx = SUM_W'(cap);
    if (sum >= capx) begin
      sum = sum - capx;
    end
    return sum[ADDR_W-1:0];
  endfunction

  // zero acts as one, above depth acts as depth
  always_comb begin
    if (cfg_data_i == '0) begin
      cap_new = CNT_W'(1);
    end else if (cfg_data_i > CNT_W'(MAX_DEPTH)) begin
      cap_new = CNT_W'(MAX_DEPTH);
    end else begin
      cap_new = cfg_data_i;
    end
  end

  assign pos_b    = k_q - CNT_W'(1) - CNT_W'(i_q);
  assign slot_a   = wrap_add(head_q, i_q, cap_q);
  assign slot_b   = wrap_add(head_q, pos_b[ADDR_W-1:0], cap_q);
  assign tail_inc = wrap_add(tail_q, ADDR_W'(1), cap_q);

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= ADDR_W'(MAX_DEPTH - 1);
      count_q <= '0;
      cap_q   <= CNT_W'(MAX_DEPTH);
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    val_q    <= val_d;
    k_q      <= k_d;
    i_q      <= i_d;
    status_q <= status_d;
    pop_q    <= pop_d;
  end

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    cap_d    = cap_q;
    func_d   = func_q;
    val_d    = val_q;
    k_d      = k_q;
    i_d      = i_q;
    status_d = status_q;
    pop_d    = pop_q;
    mem_o    = '0;
    rsp_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d   = func_e'(func_i);
          val_d    = value_i;
          k_d      = k_i;
          pop_d    = '0;
          status_d = ST_OK;
          state_d  = S_OP;
        end else if (cfg_valid_i) begin
          cap_d   = cap_new;
          head_d  = '0;
          tail_d  = ADDR_W'(cap_new - CNT_W'(1));
          count_d = '0;
        end
      end
      S_OP: begin
        state_d = S_HEAD;
        unique case (func_q)
          FN_ENQ: begin
            if (count_q >= cap_q) begin
              status_d = ST_FULL;
            end else begin
              mem_o.we = 1'b1;
              mem_o.wa = tail_inc;
              mem_o.wd = val_q;
              tail_d   = tail_inc;
              count_d  = count_q + CNT_W'(1);
            end
          end
          FN_DEQ: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              mem_o.re0 = 1'b1;
              mem_o.ra0 = head_q;
              state_d   = S_POP;
            end
          end
          FN_REV: begin
            if (k_q <= CNT_W'(1) || k_q > count_q) begin
              status_d = ST_REJECT;
            end else begin
              i_d     = '0;
              state_d = S_SWRD;
            end
          end
          default: begin
            state_d = S_HEAD;
          end
        endcase
      end
      S_POP: begin
        pop_d   = rd0_i;
        head_d  = wrap_add(head_q, ADDR_W'(1), cap_q);
        count_d = count_q - CNT_W'(1);
        state_d = S_HEAD;
      end
      S_SWRD: begin
        mem_o.re0 = 1'b1;
        mem_o.ra0 = slot_a;
        mem_o.re1 = 1'b1;
        mem_o.ra1 = slot_b;
        state_d   = S_SWA;
      end
      S_SWA: begin
        mem_o.we = 1'b1;
        mem_o.wa = slot_a;
        mem_o.wd = rd1_i;
        state_d  = S_SWB;
      end
      S_SWB: begin
        mem_o.we = 1'b1;
        mem_o.wa = slot_b;
        mem_o.wd = rd0_i;
        i_d      = i_q + ADDR_W'(1);
        if ((CNT_W'(i_q) + CNT_W'(1)) == (k_q >> 1)) begin
          state_d = S_HEAD;
        end else begin
          state_d = S_SWRD;
        end
      end
      S_HEAD: begin
        mem_o.re0 = 1'b1;
        mem_o.ra0 = head_q;
        state_d   = S_RESP;
      end
      S_RESP: begin
        rsp_o.valid  = 1'b1;
        rsp_o.status = status_q;
        rsp_o.popped = pop_q;
        rsp_o.count  = count_q;
        rsp_o.empty  = (count_q == '0);
        rsp_o.full   = (count_q >= cap_q);
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[tb/sv/tb_ring_queue_reverse_prefix.sv]
// Testbench for the ring queue with reverse of the oldest k entries.
`timescale 1ns / 1ps
module tb_ring_queue_reverse_prefix
  import rqrp_pkg::*;
();

  // Cycles with no handshake of any kind before the run is called hung.
  // The slowest item is a reverse of 16 behind the longest sender gap.
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 135;

  // One result as the block reports it.
  typedef struct {
    logic signed [DATA_WIDTH-1:0] pop_value;
    status_e                      status;
    logic [CNT_W-1:0]             occupancy;
    logic                         is_empty;
    logic                         is_full;
    logic signed [DATA_WIDTH-1:0] head_value;
  } reply_t;

  // Mirror of the queue: ring contents, pointers and capacity, plus the
  // replies owed by the block in issue order.
  class ring_mirror;
    logic signed [DATA_WIDTH-1:0] slots [MAX_DEPTH];
    int unsigned head, tail, count, cap;
    reply_t      owed [$];
    int unsigned faults, checked;
    int unsigned status_hits [4];

    // Out-of-range register values clamp; any write also empties the ring.
    function void set_capacity(logic [CNT_W-1:0] raw);
      if (raw == 0) cap = 1;
      else if (raw > MAX_DEPTH) cap = MAX_DEPTH;
      else cap = 32'(raw);
      head  = 0;
      tail  = cap - 1;
      count = 0;
    endfunction

    function void note_command(func_e fn, logic signed [DATA_WIDTH-1:0] value,
                               logic [CNT_W-1:0] k);
      reply_t                       r;
      logic signed [DATA_WIDTH-1:0] t;
      int unsigned                  a, b;
      r.pop_value = '0;
      r.status    = ST_OK;
      case (fn)
        FN_ENQ: begin
          if (count >= cap) r.status = ST_FULL;
          else begin
            tail        = (tail + 1) % cap;
            slots[tail] = value;
            count++;
          end
        end
        FN_DEQ: begin
          if (count == 0) r.status = ST_EMPTY;
          else begin
            r.pop_value = slots[head];
            head        = (head + 1) % cap;
            count--;
          end
        end
        FN_REV: begin
          if (k <= 1 || k > count) r.status = ST_REJECT;
          else begin
            // swap outer pairs of the k oldest, walking inward
            for (int i = 0; i < k / 2; i++) begin
              a        = (head + i) % cap;
              b        = (head + k - 1 - i) % cap;
              t        = slots[a];
              slots[a] = slots[b];
              slots[b] = t;
            end
          end
        end
        default: ;
      endcase
      r.occupancy  = CNT_W'(count);
      r.is_empty   = (count == 0);
      r.is_full    = (count >= cap);
      r.head_value = (count == 0) ? '0 : slots[head];
      status_hits[r.status]++;
      owed.push_back(r);
    endfunction

    function string show(reply_t r);
      return $sformatf("pop=%0d st=%0d occ=%0d empty=%0b full=%0b head=%0d",
                       r.pop_value, r.status, r.occupancy, r.is_empty, r.is_full,
                       r.head_value);
    endfunction

    function void log_fault(string msg);
      faults++;
      if (faults <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (owed.size() == 0) begin
        log_fault({"result with nothing outstanding: ", show(got)});
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.pop_value !== want.pop_value || got.status !== want.status ||
          got.occupancy !== want.occupancy || got.is_empty !== want.is_empty ||
          got.is_full !== want.is_full || got.head_value !== want.head_value)
        log_fault($sformatf("result %0d expected %s, got %s", checked, show(want),
                            show(got)));
    endfunction
  endclass

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         start           = 1'b0;
  logic                         busy;
  logic [1:0]                   func_i          = FN_NOP;
  logic signed [DATA_WIDTH-1:0] push_value_i    = '0;
  logic [CNT_W-1:0]             reverse_count_i = '0;
  logic                         cfg_valid_i     = 1'b0;
  logic                         cfg_ready_o;
  logic [CNT_W-1:0]             cfg_data_i      = '0;
  logic                         res_valid_o;
  logic signed [DATA_WIDTH-1:0] pop_value_o;
  logic [1:0]                   status_o;
  logic [CNT_W-1:0]             occupancy_o;
  logic                         is_empty_o;
  logic                         is_full_o;
  logic signed [DATA_WIDTH-1:0] head_value_o;

  ring_mirror  mirror;
  int unsigned idle_pct;      // chance in 100 that the sender idles after an item
  int unsigned items_sent;
  int unsigned cap_writes;
  int unsigned stall_cycles;

  // capacities per random phase: extremes, clamped values and a few in between
  logic [CNT_W-1:0] phase_caps [PHASES] = '{16, 5, 31, 2, 16, 9, 0, 3, 16, 1, 12, 16};

  always #4 clk_i = ~clk_i;

  ring_queue_reverse_prefix uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .reverse_count_i(reverse_count_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .res_valid_o    (res_valid_o),
    .pop_value_o    (pop_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .head_value_o   (head_value_o)
  );

  // Results live for one cycle and cannot be held off; take each at its edge.
  always @(posedge clk_i) begin
    reply_t got;
    if (rst_ni && res_valid_o === 1'b1) begin
      got.pop_value  = pop_value_o;
      got.status     = status_e'(status_o);
      got.occupancy  = occupancy_o;
      got.is_empty   = is_empty_o;
      got.is_full    = is_full_o;
      got.head_value = head_value_o;
      mirror.check_reply(got);
    end
  end

  // Watchdog: any accepted item, result or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && busy === 1'b0) || res_valid_o === 1'b1 ||
                 (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL ring_queue_reverse_prefix");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one command and hold it until the block takes it. Start stays high on
  // return so back-to-back items need no extra assignment in the accept step.
  task automatic issue(func_e fn, logic signed [DATA_WIDTH-1:0] value,
                       logic [CNT_W-1:0] k);
    start           <= 1'b1;
    func_i          <= fn;
    push_value_i    <= value;
    reverse_count_i <= k;
    do @(posedge clk_i); while (busy !== 1'b0);
    mirror.note_command(fn, value, k);
    items_sent++;
  endtask

  // Sender gap after an item; lengths spread so start rises at many points while the block is busy.
  task automatic pace();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  endtask

  // Stop sending until every outstanding result is back.
  task automatic drain_queue();
    start <= 1'b0;
    while (mirror.owed.size() != 0) @(posedge clk_i);
  endtask

  // Capacity write only with the block idle; the write also empties the ring.
  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain_queue();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    mirror.set_capacity(value);
    cap_writes++;
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] random_word();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  // Bursts of one kind of command so the ring fills, empties and wraps often;
  // reverses mostly carry a legal k, the rest is noise.
  task automatic run_random(int unsigned n);
    int unsigned      done;
    int unsigned      kind;
    int unsigned      burst;
    logic [CNT_W-1:0] k;
    done = 0;
    while (done < n) begin
      kind  = $urandom_range(0, 9);
      burst = $urandom_range(1, mirror.cap + 2);
      for (int j = 0; j < burst && done < n; j++) begin
        if (mirror.count >= 2 && $urandom_range(0, 4) != 0)
          k = ($urandom_range(0, 3) == 0) ? CNT_W'(mirror.count)
                                          : CNT_W'($urandom_range(2, mirror.count));
        else
          k = CNT_W'($urandom_range(0, 31));
        if (kind <= 3) issue(FN_ENQ, random_word(), CNT_W'($urandom_range(0, 31)));
        else if (kind <= 6) issue(FN_DEQ, random_word(), CNT_W'($urandom_range(0, 31)));
        else if (kind <= 8) issue(FN_REV, random_word(), k);
        else issue(func_e'(2'($urandom_range(0, 3))), random_word(), k);
        done++;
        if ($urandom_range(0, 199) == 0) drain_queue();
        else pace();
      end
    end
  endtask

  initial begin
    mirror = new;
    mirror.set_capacity(CNT_W'(MAX_DEPTH));
    idle_pct = 33;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset capacity of 16: empty cases first, then value extremes
    // and every way a reverse gets rejected or taken.
    issue(FN_DEQ, 0, 0);                 pace();  // pop from empty
    issue(FN_REV, 0, 2);                 pace();  // reverse on empty
    issue(FN_NOP, 32'sh1234_5678, 31);   pace();  // unused code
    issue(FN_ENQ, 32'sh7fff_ffff, 0);    pace();
    issue(FN_ENQ, 32'sh8000_0000, 0);    pace();
    issue(FN_ENQ, -1, 0);                pace();
    issue(FN_ENQ, 0, 0);                 pace();
    issue(FN_ENQ, 1, 0);                 pace();
    issue(FN_REV, 0, 0);                 pace();  // k of zero
    issue(FN_REV, 0, 1);                 pace();  // k of one
    issue(FN_REV, 0, 6);                 pace();  // k above count
    issue(FN_REV, 0, 5);                 pace();  // whole queue, odd k
    issue(FN_REV, 0, 2);                 pace();  // smallest legal k
    issue(FN_NOP, -1, 16);               pace();
    issue(FN_DEQ, -1, 31);               pace();
    issue(FN_DEQ, 0, 0);                 pace();

    // Single-entry ring: full after one push.
    write_capacity(1);
    issue(FN_ENQ, 32'sh5555_5555, 0);    pace();
    issue(FN_ENQ, 32'sh0f0f_0f0f, 0);    pace();  // dropped, full
    issue(FN_REV, 0, 2);                 pace();  // k above count
    issue(FN_DEQ, 0, 0);                 pace();
    issue(FN_DEQ, 0, 0);                 pace();  // empty again

    // Register value of zero clamps to one entry.
    write_capacity(0);
    issue(FN_ENQ, 32'shaaaa_aaaa, 0);    pace();
    issue(FN_ENQ, 32'sh0000_0001, 0);    pace();  // dropped, full

    // Random phases: sender idles now and then, then often, then not at all.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p < 4) ? 33 : ((p < 8) ? 65 : 0);
      write_capacity(phase_caps[p]);
      run_random(PHASE_ITEMS);
    end

    drain_queue();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mirror.owed.size() != 0)
      mirror.log_fault($sformatf("%0d results never arrived", mirror.owed.size()));

    $display("ran %0d commands under %0d capacity writes, %0d results checked",
             items_sent, cap_writes, mirror.checked);
    $display("status mix: ok %0d, full drop %0d, empty pop %0d, reverse rejected %0d",
             mirror.status_hits[ST_OK], mirror.status_hits[ST_FULL],
             mirror.status_hits[ST_EMPTY], mirror.status_hits[ST_REJECT]);
    if (mirror.faults == 0) begin
      $display("PASS ring_queue_reverse_prefix");
    end else begin
      $display("%0d mismatches", mirror.faults);
      $display("FAIL ring_queue_reverse_prefix");
    end
    $finish;
  end

endmodule

[files.f]
sv/rqrp_pkg.sv
sv/rqrp_ram.sv
sv/rqrp_seq.sv
sv/ring_queue_reverse_prefix.sv
tb/sv/tb_ring_queue_reverse_prefix.sv
